// ===== hw/rtl/char_lcd_nibble_interface_core_defines.svh =====
// ----------------------------------------------------------------------------
// Character LCD nibble interface: assertion macros
// Shared property shorthands for the checker, clocked on clk_i and held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_INTERFACE_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_CORE_DEFINES_SVH

// Same-cycle implication.
`define LCD4_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LCD4_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lcd4_pkg.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble interface: package
// Request codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package lcd4_pkg;

  localparam int unsigned DelayBits = 16;
  localparam logic [31:0] DelayMax  = 32'((64'd1 << DelayBits) - 64'd1);

  typedef logic [DelayBits-1:0] delay_t;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_CMD    = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_CURSOR = 3'd3,
    KIND_CLEAR  = 3'd4,
    KIND_INIT   = 3'd5
  } kind_e;

  localparam logic [2:0] RegPulseWidth  = 3'd0;
  localparam logic [2:0] RegCommandWait = 3'd1;
  localparam logic [2:0] RegInitGap     = 3'd2;
  localparam logic [2:0] RegPowerupWait = 3'd3;
  localparam logic [2:0] RegClearWait   = 3'd4;
  localparam logic [2:0] RegFunctionSet = 3'd5;
  localparam logic [2:0] RegDisplayCtl  = 3'd6;
  localparam logic [2:0] RegEntryMode   = 3'd7;

  localparam logic [7:0]  RstPulseWidth  = 8'd1;
  localparam logic [15:0] RstCommandWait = 16'd100;
  localparam logic [15:0] RstInitGap     = 16'd5000;
  localparam logic [15:0] RstPowerupWait = 16'd50000;
  localparam logic [15:0] RstClearWait   = 16'd2000;
  localparam logic [7:0]  RstFunctionSet = 8'h28;
  localparam logic [7:0]  RstDisplayCtl  = 8'h0C;
  localparam logic [7:0]  RstEntryMode   = 8'h06;

  localparam logic [7:0] CmdClear     = 8'h01;
  localparam logic [7:0] CmdSetDdram  = 8'h80;
  localparam logic [3:0] NibbleSync   = 4'h3;
  localparam logic [3:0] NibbleBus4   = 4'h2;

  typedef struct packed {
    logic [7:0]  pulse_width;
    logic [15:0] command_wait;
    logic [15:0] init_gap;
    logic [15:0] powerup_wait;
    logic [15:0] clear_wait;
    logic [7:0]  function_set;
    logic [7:0]  display_control;
    logic [7:0]  entry_mode;
  } cfg_t;

  function automatic logic [6:0] row_offset(input logic [1:0] row);
    logic [6:0] off;
    case (row)
      2'd0: off = 7'h00;
      2'd1: off = 7'h40;
      2'd2: off = 7'h14;
      2'd3: off = 7'h54;
      default: off = 7'h00;
    endcase
    return off;
  endfunction

  function automatic delay_t sat_delay(input logic [15:0] d);
    logic [31:0] w;
    w = 32'(d);
    if (w > DelayMax) begin
      return delay_t'(DelayMax);
    end
    return delay_t'(w);
  endfunction

endpackage

// ===== hw/rtl/lcd4_cfg.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble interface: configuration registers
// Timing and init words, written by index and loaded with defaults at reset.
// ----------------------------------------------------------------------------
module lcd4_cfg import lcd4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPulseWidth:  cfg_d.pulse_width     = cfg_wdata_i[7:0];
        RegCommandWait: cfg_d.command_wait    = cfg_wdata_i;
        RegInitGap:     cfg_d.init_gap        = cfg_wdata_i;
        RegPowerupWait: cfg_d.powerup_wait    = cfg_wdata_i;
        RegClearWait:   cfg_d.clear_wait      = cfg_wdata_i;
        RegFunctionSet: cfg_d.function_set    = cfg_wdata_i[7:0];
        RegDisplayCtl:  cfg_d.display_control = cfg_wdata_i[7:0];
        RegEntryMode:   cfg_d.entry_mode      = cfg_wdata_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_width     <= RstPulseWidth;
      cfg_q.command_wait    <= RstCommandWait;
      cfg_q.init_gap        <= RstInitGap;
      cfg_q.powerup_wait    <= RstPowerupWait;
      cfg_q.clear_wait      <= RstClearWait;
      cfg_q.function_set    <= RstFunctionSet;
      cfg_q.display_control <= RstDisplayCtl;
      cfg_q.entry_mode      <= RstEntryMode;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/char_lcd_nibble_interface_core.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble interface core
// Sequences commands, characters, cursor moves, clears and the power-up init
// onto a 4-bit LCD bus, timed by one-microsecond tick items.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o   kind, byte_value, column, row
//   out      output     out_valid_o/out_stall_i rs, enable, nibble, busy, reject
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One item is accepted per cycle while the input side is not stalled; its result is presented
// once the input register has passed it to the result register.
// Reset returns the sequencer to idle and loads the default timing.
// A held result stalls the input side only once the input register is full.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_core import lcd4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  byte_value_i,
  input  logic [5:0]  column_i,
  input  logic [1:0]  row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        rs_line_o,
  output logic        enable_line_o,
  output logic [3:0]  data_nibble_o,
  output logic        busy_res_o,
  output logic        rejected_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_POWERUP    = 4'd1,
    PH_EN_LOW1    = 4'd2,
    PH_EN_HIGH    = 4'd3,
    PH_EN_LOW2    = 4'd4,
    PH_CMD_WAIT   = 4'd5,
    PH_INIT_GAP   = 4'd6,
    PH_CLEAR_WAIT = 4'd7
  } phase_e;

  localparam logic [3:0] StepNone    = 4'd0;
  localparam logic [3:0] StepPowerup = 4'd1;
  localparam logic [3:0] StepSyncA   = 4'd2;
  localparam logic [3:0] StepSyncB   = 4'd3;
  localparam logic [3:0] StepSyncC   = 4'd4;
  localparam logic [3:0] StepBus4    = 4'd5;
  localparam logic [3:0] StepFuncSet = 4'd6;
  localparam logic [3:0] StepDispCtl = 4'd7;
  localparam logic [3:0] StepEntry   = 4'd8;
  localparam logic [3:0] StepClear   = 4'd9;

  typedef struct packed {
    phase_e     phase;
    delay_t     delay;
    logic [7:0] byte_latch;
    logic       sel;
    logic       second;
    logic [3:0] step;
    logic       clr;
    logic       en;
    logic [3:0] data;
  } seq_t;

  cfg_t cfg;

  lcd4_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  function automatic delay_t pulse_len(input cfg_t c);
    return (c.pulse_width == 8'd0) ? delay_t'(1) : sat_delay(16'(c.pulse_width));
  endfunction

  function automatic seq_t start_nibble(input seq_t s, input logic [3:0] n, input cfg_t c);
    seq_t r;
    r       = s;
    r.data  = n;
    r.en    = 1'b0;
    r.phase = PH_EN_LOW1;
    r.delay = pulse_len(c);
    return r;
  endfunction

  function automatic seq_t start_byte(input seq_t s, input logic [7:0] b, input logic rs,
                                      input cfg_t c);
    seq_t r;
    r            = s;
    r.byte_latch = b;
    r.sel        = rs;
    r.second     = 1'b0;
    return start_nibble(r, b[7:4], c);
  endfunction

  function automatic seq_t begin_step(input seq_t s, input cfg_t c);
    seq_t r;
    r = s;
    case (s.step)
      StepPowerup: begin
        r.phase = PH_POWERUP;
        r.delay = sat_delay(c.powerup_wait);
      end
      StepSyncA, StepSyncB, StepSyncC: begin
        r.sel = 1'b0;
        r     = start_nibble(r, NibbleSync, c);
      end
      StepBus4: begin
        r.sel = 1'b0;
        r     = start_nibble(r, NibbleBus4, c);
      end
      StepFuncSet: r = start_byte(r, c.function_set, 1'b0, c);
      StepDispCtl: r = start_byte(r, c.display_control, 1'b0, c);
      StepEntry:   r = start_byte(r, c.entry_mode, 1'b0, c);
      StepClear: begin
        r     = start_byte(r, CmdClear, 1'b0, c);
        r.clr = 1'b1;
      end
      default: begin
        r.step  = StepNone;
        r.phase = PH_IDLE;
        r.delay = '0;
      end
    endcase
    return r;
  endfunction

  function automatic seq_t next_step(input seq_t s, input cfg_t c);
    seq_t r;
    r = s;
    if (s.step == StepNone) begin
      r.phase = PH_IDLE;
      r.delay = '0;
    end else begin
      r.step = s.step + 4'd1;
      r      = begin_step(r, c);
    end
    return r;
  endfunction

  function automatic seq_t nibble_done(input seq_t s, input cfg_t c);
    seq_t r;
    logic byte_mode;
    r         = s;
    byte_mode = (s.step == StepNone) || (s.step >= StepFuncSet);
    if (byte_mode && !s.second) begin
      r.second = 1'b1;
      r        = start_nibble(r, s.byte_latch[3:0], c);
    end else if (s.step >= StepSyncA && s.step <= StepSyncC) begin
      r.phase = PH_INIT_GAP;
      r.delay = sat_delay(c.init_gap);
    end else if (s.clr) begin
      r.clr   = 1'b0;
      r.phase = PH_CLEAR_WAIT;
      r.delay = sat_delay(c.clear_wait);
    end else begin
      r = next_step(r, c);
    end
    return r;
  endfunction

  function automatic seq_t end_phase(input seq_t s, input cfg_t c);
    seq_t r;
    r = s;
    case (s.phase)
      PH_EN_LOW1: begin
        r.en    = 1'b1;
        r.phase = PH_EN_HIGH;
        r.delay = pulse_len(c);
      end
      PH_EN_HIGH: begin
        r.en    = 1'b0;
        r.phase = PH_EN_LOW2;
        r.delay = pulse_len(c);
      end
      PH_EN_LOW2: begin
        r.phase = PH_CMD_WAIT;
        r.delay = (c.command_wait == 16'd0) ? delay_t'(1) : sat_delay(c.command_wait);
      end
      PH_CMD_WAIT: r = nibble_done(s, c);
      PH_POWERUP, PH_INIT_GAP, PH_CLEAR_WAIT: r = next_step(s, c);
      default: begin
        r.phase = PH_IDLE;
        r.delay = '0;
      end
    endcase
    return r;
  endfunction

  // Input register.
  logic       in_vld_q;
  logic [2:0] kind_q;
  logic [7:0] byte_q;
  logic [5:0] col_q;
  logic [1:0] row_q;

  // Sequencer state and result register.
  seq_t       st_q, st_d;
  logic       out_vld_q;
  logic       rs_q, en_q, busy_q, rej_q;
  logic [3:0] nib_q;
  logic       rej_d;

  logic advance, accept_in;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept_in  = in_valid_i && !in_stall_o;

  always_comb begin
    logic [6:0] addr;
    st_d  = st_q;
    rej_d = 1'b0;
    addr  = 7'(col_q) + row_offset(row_q);
    case (kind_q)
      KIND_TICK: begin
        if (st_d.phase != PH_IDLE && st_d.delay != '0) begin
          st_d.delay = st_d.delay - delay_t'(1);
        end
      end
      KIND_CMD, KIND_DATA, KIND_CURSOR, KIND_CLEAR, KIND_INIT: begin
        if (st_q.phase != PH_IDLE) begin
          rej_d = 1'b1;
        end else begin
          st_d.step = StepNone;
          st_d.clr  = 1'b0;
          case (kind_q)
            KIND_CMD:    st_d = start_byte(st_d, byte_q, 1'b0, cfg);
            KIND_DATA:   st_d = start_byte(st_d, byte_q, 1'b1, cfg);
            KIND_CURSOR: st_d = start_byte(st_d, CmdSetDdram | {1'b0, addr}, 1'b0, cfg);
            KIND_CLEAR: begin
              st_d     = start_byte(st_d, CmdClear, 1'b0, cfg);
              st_d.clr = 1'b1;
            end
            default: begin
              st_d.step = StepPowerup;
              st_d      = begin_step(st_d, cfg);
            end
          endcase
        end
      end
      default: st_d = st_q;
    endcase
    // Zero-length waits fall through; at most two phase ends chain per item.
    for (int i = 0; i < 2; i++) begin
      if (st_d.phase != PH_IDLE && st_d.delay == '0) begin
        st_d = end_phase(st_d, cfg);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      kind_q <= kind_i;
      byte_q <= byte_value_i;
      col_q  <= column_i;
      row_q  <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{phase: PH_IDLE, default: '0};
      rs_q      <= 1'b0;
      en_q      <= 1'b0;
      nib_q     <= 4'd0;
      busy_q    <= 1'b0;
      rej_q     <= 1'b0;
    end else begin
      if (accept_in) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        st_q      <= st_d;
        out_vld_q <= 1'b1;
        rs_q      <= st_d.sel;
        en_q      <= st_d.en;
        nib_q     <= st_d.data;
        busy_q    <= (st_d.phase != PH_IDLE);
        rej_q     <= rej_d;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign rs_line_o     = rs_q;
  assign enable_line_o = en_q;
  assign data_nibble_o = nib_q;
  assign busy_res_o    = busy_q;
  assign rejected_o    = rej_q;

endmodule

// ===== hw/rtl/lcd4_checker.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble interface: port checker
// Watches the top-level ports and flags results or stalls that cannot occur.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_interface_core_defines.svh"

module lcd4_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        rs_line_o,
  input logic        enable_line_o,
  input logic [3:0]  data_nibble_o,
  input logic        busy_res_o,
  input logic        rejected_o
);

  `LCD4_ASSERT_IMP(a_reject_busy, out_valid_o && rejected_o, busy_res_o, "reject while idle")
  `LCD4_ASSERT_IMP(a_enable_busy, out_valid_o && enable_line_o, busy_res_o, "enable high while idle")
  `LCD4_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without a held result")
  `LCD4_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(rs_line_o) && $stable(enable_line_o) && $stable(data_nibble_o) && $stable(busy_res_o) && $stable(rejected_o), "stalled result changed")

endmodule

bind char_lcd_nibble_interface_core lcd4_checker u_lcd4_checker (.*);
